[design/ialu_pkg.sv]
// Shared types, opcodes and controller/datapath interface structs for the
// integer ALU with power. No dependencies.
package ialu_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int OP_WIDTH   = 3;
    localparam int CNT_WIDTH  = $clog2(WORD_WIDTH);

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [OP_WIDTH-1:0]   t_op;
    typedef logic [CNT_WIDTH-1:0]  t_cnt;

    localparam t_op OP_ADD = 3'd0;
    localparam t_op OP_SUB = 3'd1;
    localparam t_op OP_MUL = 3'd2;
    localparam t_op OP_DIV = 3'd3;
    localparam t_op OP_REM = 3'd4;
    localparam t_op OP_POW = 3'd5;
    localparam t_op OP_CMP = 3'd6;

    localparam t_cnt CNT_LAST = CNT_WIDTH'(WORD_WIDTH - 1);

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic run_done;
    } t_status;

endpackage

[design/ialu_ctrl.sv]
// Controller state machine for the integer ALU: load, iterate, finish.
// Depends on ialu_pkg for the command and status structs.
module ialu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ialu_pkg::t_status i_status,
    output ialu_pkg::t_cmd    o_cmd,
    output logic              busy,
    output logic              o_done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_done;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_status.run_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.finish;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

[design/ialu_dpath.sv]
// Datapath for the integer ALU: operand registers, restoring divider,
// square-and-multiply power and the result register.
// Depends on ialu_pkg.
module ialu_dpath (
    input  logic              i_clk,
    input  ialu_pkg::t_cmd    i_cmd,
    input  ialu_pkg::t_op     i_op,
    input  ialu_pkg::t_word   i_operand_a,
    input  ialu_pkg::t_word   i_operand_b,
    output ialu_pkg::t_status o_status,
    output ialu_pkg::t_word   o_value,
    output logic              o_error_code
);

    localparam int W = ialu_pkg::WORD_WIDTH;

    ialu_pkg::t_op   r_op;
    ialu_pkg::t_word r_a;
    ialu_pkg::t_word r_b;
    ialu_pkg::t_word r_acc;
    ialu_pkg::t_word r_rem;
    ialu_pkg::t_cnt  r_cnt;
    logic            r_neg_a;
    logic            r_neg_b;
    ialu_pkg::t_word r_value;
    logic            r_err;

    logic            ld_div;
    ialu_pkg::t_word mag_a;
    ialu_pkg::t_word mag_b;
    logic            is_divop;
    logic            iter_div;
    logic            iter_pow;
    ialu_pkg::t_word mul_y;
    ialu_pkg::t_word prod;
    ialu_pkg::t_word square;
    logic [W:0]      trial;
    ialu_pkg::t_word n_value;
    logic            n_err;

    assign ld_div = (i_op == ialu_pkg::OP_DIV) || (i_op == ialu_pkg::OP_REM);
    assign mag_a  = i_operand_a[W-1] ? (~i_operand_a + 1'b1) : i_operand_a;
    assign mag_b  = i_operand_b[W-1] ? (~i_operand_b + 1'b1) : i_operand_b;

    assign is_divop = (r_op == ialu_pkg::OP_DIV) || (r_op == ialu_pkg::OP_REM);
    assign iter_div = is_divop && (r_b != '0);
    assign iter_pow = (r_op == ialu_pkg::OP_POW) && !r_b[W-1];

    assign mul_y  = (r_op == ialu_pkg::OP_POW) ? r_acc : r_b;
    assign prod   = r_a * mul_y;
    assign square = r_a * r_a;
    assign trial  = {r_rem, r_a[W-1]} - {1'b0, r_b};

    always_comb begin
        if (iter_div) begin
            o_status.run_done = (r_cnt == ialu_pkg::CNT_LAST);
        end else if (iter_pow) begin
            o_status.run_done = (r_b[W-1:1] == '0);
        end else begin
            o_status.run_done = 1'b1;
        end
    end

    always_comb begin
        n_value = '0;
        n_err   = 1'b0;
        case (r_op)
            ialu_pkg::OP_ADD: n_value = r_a + r_b;
            ialu_pkg::OP_SUB: n_value = r_a - r_b;
            ialu_pkg::OP_MUL: n_value = prod;
            ialu_pkg::OP_DIV: begin
                if (r_b == '0) begin
                    n_err = 1'b1;
                end else begin
                    n_value = (r_neg_a ^ r_neg_b) ? (~r_a + 1'b1) : r_a;
                end
            end
            ialu_pkg::OP_REM: begin
                if (r_b == '0) begin
                    n_err = 1'b1;
                end else begin
                    n_value = r_neg_a ? (~r_rem + 1'b1) : r_rem;
                end
            end
            ialu_pkg::OP_POW: begin
                if (!r_b[W-1]) begin
                    n_value = r_acc;
                end else if (r_a == '1) begin
                    n_value = r_b[0] ? '1 : W'(1);
                end else if (r_a == '0) begin
                    n_err = 1'b1;
                end else if (r_a == W'(1)) begin
                    n_value = W'(1);
                end
            end
            ialu_pkg::OP_CMP: begin
                if ($signed(r_a) < $signed(r_b)) begin
                    n_value = '1;
                end else if (r_a != r_b) begin
                    n_value = W'(1);
                end
            end
            default: n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_a     <= ld_div ? mag_a : i_operand_a;
            r_b     <= ld_div ? mag_b : i_operand_b;
            r_neg_a <= i_operand_a[W-1];
            r_neg_b <= i_operand_b[W-1];
            r_acc   <= W'(1);
            r_rem   <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.step) begin
            if (iter_div) begin
                r_cnt <= r_cnt + 1'b1;
                if (!trial[W]) begin
                    r_rem <= trial[W-1:0];
                    r_a   <= {r_a[W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[W-2:0], r_a[W-1]};
                    r_a   <= {r_a[W-2:0], 1'b0};
                end
            end else if (iter_pow) begin
                if (r_b[0]) begin
                    r_acc <= prod;
                end
                r_a <= square;
                r_b <= {1'b0, r_b[W-1:1]};
            end
        end
        if (i_cmd.finish) begin
            r_value <= n_value;
            r_err   <= n_err;
        end
    end

    assign o_value      = r_value;
    assign o_error_code = r_err;

endmodule

[design/integer_alu_with_power.sv]
// Top level of the signed integer ALU with power.
// Depends on ialu_pkg, ialu_ctrl and ialu_dpath.
//
// Usage: drive i_op, i_operand_a and i_operand_b and raise start while busy
// is low; the item is taken at that clock edge. busy stays high until the
// result is ready. o_done is high for exactly one cycle with o_value and
// o_error_code; the receiver must take it then, it cannot stall the block.
// busy is already low in that strobe cycle, so a new item may start there.
// Sequence: the accepting edge loads the operands; the controller then runs
// the iteration steps, then a finish state that registers the result, and
// the strobe follows. Add, subtract, multiply, compare, zero-divisor and
// negative-exponent cases need no iteration. Divide and remainder produce one
// quotient bit per cycle in the restoring divider. Power takes n steps,
// n = index of the highest set exponent bit plus one (minimum 1), one
// square-and-multiply step per cycle.
// Items do not overlap; start is ignored while busy is high.
// Reset (i_rst_n low, synchronous) returns the controller to idle and drops
// o_done; datapath registers (o_value, o_error_code included) are not reset.
module integer_alu_with_power (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  ialu_pkg::t_op                         i_op,
    input  logic signed [ialu_pkg::WORD_WIDTH-1:0] i_operand_a,
    input  logic signed [ialu_pkg::WORD_WIDTH-1:0] i_operand_b,
    output logic                                  o_done,
    output logic signed [ialu_pkg::WORD_WIDTH-1:0] o_value,
    output logic                                  o_error_code
);

    ialu_pkg::t_cmd    cmd;
    ialu_pkg::t_status status;
    ialu_pkg::t_word   value;

    ialu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    ialu_dpath u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_op         (i_op),
        .i_operand_a  (ialu_pkg::t_word'(i_operand_a)),
        .i_operand_b  (ialu_pkg::t_word'(i_operand_b)),
        .o_status     (status),
        .o_value      (value),
        .o_error_code (o_error_code)
    );

    assign o_value = $signed(value);

endmodule
